// File: rtl/core/cgps_pkg.sv
`default_nettype none

package cgps_pkg;

  // Pitch range in half-semitone steps
  localparam int LOWEST_HALF_STEP  = -24;
  localparam int HIGHEST_HALF_STEP = 5;

  // Rate table spans half steps RomBase .. RomBase + RomSize - 1
  localparam int RomBase = -24;
  localparam int RomSize = 30;

  localparam logic [15:0] WindowReset = 16'd250;

  localparam logic signed [6:0] PitchLo  = 7'(LOWEST_HALF_STEP);
  localparam logic signed [6:0] PitchHi  = 7'(HIGHEST_HALF_STEP);
  localparam logic signed [6:0] RomBase7 = 7'(RomBase);
  localparam logic signed [6:0] RomLast  = 7'(RomSize - 1);

  typedef enum logic [2:0] {
    GestNone       = 3'd0,
    GestSingleUp   = 3'd1,
    GestSingleDown = 3'd2,
    GestDoubleUp   = 3'd3,
    GestDoubleDown = 3'd4
  } gesture_e;

  // Encoder direction as it arrives on the bus
  localparam logic [1:0] DirNone = 2'b00;
  localparam logic [1:0] DirUp   = 2'b01;

  typedef struct packed {
    logic        action;    // 1 = click, 0 = tick
    logic [1:0]  click_dir;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    gesture_e          gesture;
    logic signed [5:0] pitch_half;
    logic [16:0]       ratio_q16;
  } result_t;

  // round(65536 * 2^(k/24)) for k = -24 .. +5
  localparam logic [16:0] RATE_ROM [RomSize] = '{
    17'd32768, 17'd33728, 17'd34716, 17'd35734, 17'd36781, 17'd37859,
    17'd38968, 17'd40110, 17'd41285, 17'd42495, 17'd43740, 17'd45022,
    17'd46341, 17'd47699, 17'd49097, 17'd50535, 17'd52016, 17'd53540,
    17'd55109, 17'd56724, 17'd58386, 17'd60097, 17'd61858, 17'd63670,
    17'd65536, 17'd67456, 17'd69433, 17'd71468, 17'd73562, 17'd75717
  };

  // Saturate a widened pitch sum to the pitch range
  function automatic logic signed [5:0] clamp_pitch(input logic signed [6:0] v);
    logic signed [6:0] r;
    r = v;
    if (v < PitchLo) begin
      r = PitchLo;
    end else if (v > PitchHi) begin
      r = PitchHi;
    end
    return r[5:0];
  endfunction

  // Look up the playback rate, saturating the index at the table ends
  function automatic logic [16:0] rate_lookup(input logic signed [5:0] pitch);
    logic signed [6:0] idx;
    idx = {pitch[5], pitch} - RomBase7;
    if (idx < 7'sd0) begin
      idx = 7'sd0;
    end else if (idx > RomLast) begin
      idx = RomLast;
    end
    return RATE_ROM[idx[4:0]];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cgps_step.sv
`default_nettype none

module cgps_step (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire cgps_pkg::item_t  item_i,
  input  wire logic [15:0]      window_i,
  output cgps_pkg::result_t     res_o
);

  logic signed [5:0] pitch_q, pitch_d;
  logic              pend_q, pend_d;      // a click is pending
  logic              pend_up_q, pend_up_d;
  logic [31:0]       pend_time_q, pend_time_d;

  logic              in_window;
  logic              click_valid;
  logic              click_up;
  logic signed [6:0] delta;
  cgps_pkg::gesture_e gesture;

  // Elapsed time wraps modulo 2^32
  assign in_window   = (item_i.now_ms - pend_time_q) <= {16'd0, window_i};
  assign click_valid = item_i.click_dir != cgps_pkg::DirNone;
  assign click_up    = item_i.click_dir == cgps_pkg::DirUp;

  // Decide the gesture and the next pending click
  always_comb begin
    pend_d      = pend_q;
    pend_up_d   = pend_up_q;
    pend_time_d = pend_time_q;
    delta       = 7'sd0;
    gesture     = cgps_pkg::GestNone;
    if (item_i.action) begin
      if (click_valid) begin
        if (pend_q && (pend_up_q == click_up) && in_window) begin
          // same way inside the window: double step, drop the pending click
          pend_d  = 1'b0;
          delta   = click_up ? 7'sd2 : -7'sd2;
          gesture = click_up ? cgps_pkg::GestDoubleUp : cgps_pkg::GestDoubleDown;
        end else begin
          // commit any pending single, hold the new click
          pend_d      = 1'b1;
          pend_up_d   = click_up;
          pend_time_d = item_i.now_ms;
          if (pend_q) begin
            delta   = pend_up_q ? 7'sd1 : -7'sd1;
            gesture = pend_up_q ? cgps_pkg::GestSingleUp : cgps_pkg::GestSingleDown;
          end
        end
      end
    end else if (pend_q && !in_window) begin
      // window expired: commit the pending single
      pend_d  = 1'b0;
      delta   = pend_up_q ? 7'sd1 : -7'sd1;
      gesture = pend_up_q ? cgps_pkg::GestSingleUp : cgps_pkg::GestSingleDown;
    end
    pitch_d = cgps_pkg::clamp_pitch({pitch_q[5], pitch_q} + delta);
  end

  // Result for the current item reflects the state after it
  always_comb begin
    res_o.gesture    = gesture;
    res_o.pitch_half = pitch_d;
    res_o.ratio_q16  = cgps_pkg::rate_lookup(pitch_d);
  end

  // Advance the state on each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q     <= '0;
      pend_q      <= 1'b0;
      pend_up_q   <= 1'b0;
      pend_time_q <= '0;
    end else if (fire_i) begin
      pitch_q     <= pitch_d;
      pend_q      <= pend_d;
      pend_up_q   <= pend_up_d;
      pend_time_q <= pend_time_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/click_gesture_pitch_stepper_unit.sv
`default_nettype none

// Click-gesture pitch stepper. Each input word is an encoder click or a time
// tick with a millisecond timestamp, and each gives exactly one output word
// with the gesture, the clamped pitch offset (-24..+5 half-semitones) and its
// Q16 playback rate. Each word goes through an input register, then one pass
// of window compare, pitch clamp and table lookup into the output register.
// One word is taken every cycle; the only limit is backpressure on the output
// side. The user writes the double-click window (reset 250 ms) over the cfg
// port only while no word is in flight; the block itself does not enforce this.
module click_gesture_pitch_stepper_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: double_window_ms
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // click_dir[1:0], now_ms[33:2], zero pad
  input  wire logic        s_axis_tuser_i,  // action
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o   // gesture[2:0], pitch_half[8:3],
                                            // ratio_q16[25:9], zero pad
);

  logic [15:0]         window_q;
  logic                in_valid_q;
  cgps_pkg::item_t     in_item_q;
  logic                out_valid_q;
  cgps_pkg::result_t   out_res_q;
  cgps_pkg::result_t   step_res;
  logic                out_free;
  logic                advance;
  logic                in_take;

  // Window register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= cgps_pkg::WindowReset;
    end else if (cfg_valid_i) begin
      window_q <= cfg_data_i;
    end
  end

  // Pipeline handshake
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.action    <= s_axis_tuser_i;
      in_item_q.click_dir <= s_axis_tdata_i[1:0];
      in_item_q.now_ms    <= s_axis_tdata_i[33:2];
    end
  end

  cgps_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_item_q),
    .window_i (window_q),
    .res_o    (step_res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_res_q.ratio_q16, out_res_q.pitch_half,
                            out_res_q.gesture};

endmodule

`default_nettype wire
